// ===== design/tcma_pkg.sv =====
// shared types and constants for the two-channel moving average
package tcma_pkg;

	localparam int AVG_W      = 18;
	localparam int HELD_W     = 8;
	localparam int FRAC_W     = 8;
	localparam int LANES      = 2;
	localparam int OUT_DATA_W = 48;
	localparam int OUT_PAD_W  = OUT_DATA_W - LANES * AVG_W - HELD_W;

	typedef enum logic [3:0] {
		ST_IDLE = 4'b0001,
		ST_LOAD = 4'b0010,
		ST_DIV  = 4'b0100,
		ST_DONE = 4'b1000
	} state_t;

endpackage

// ===== design/two_channel_moving_average_top.sv =====
// two-channel boxcar moving average with a bit-serial divider for the averages
//
// Input stream s_axis: one word carries a pair of converter samples, one per
// channel. Output stream m_axis: one word per input word, with both window
// averages (unsigned, 8 fraction bits, truncated) and the number of sample
// pairs averaged, which saturates at WINDOW.
// A new input word is taken only once the previous result has left the
// divider for the output register. The restoring divider takes one
// quotient bit per cycle for both channels side by side; each word also
// passes the input handshake, the sum update and the output load.
// The output register parts the two sides: a new input word is taken while a
// finished result still waits. When the receiver stalls longer than one item
// takes, the next result waits in the divider and s_axis_tready stays low.
// Reset clears the fill count, the write slot, both sums and the valid flag.
// The ring memory is not cleared; an entry is read only after it was written.
module two_channel_moving_average_top #(
	parameter int WINDOW      = 128,
	parameter int SAMPLE_BITS = 10
) (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   s_axis_tvalid,
	output logic                                   s_axis_tready,
	// sample_a, sample_b, zero pad
	input  logic [((2*SAMPLE_BITS+7)/8)*8-1:0]     s_axis_tdata,
	output logic                                   m_axis_tvalid,
	input  logic                                   m_axis_tready,
	// average_a, average_b, samples_held, zero pad
	output logic [tcma_pkg::OUT_DATA_W-1:0]        m_axis_tdata
);

	localparam int SB     = SAMPLE_BITS;
	localparam int SLOT_W = $clog2(WINDOW);
	localparam int REM_W  = $clog2(WINDOW);
	localparam int CNT_W  = $clog2(WINDOW + 1);
	localparam int SUM_W  = SB + $clog2(WINDOW);
	localparam int Q_W    = SB + tcma_pkg::FRAC_W;
	localparam int DCNT_W = $clog2(Q_W);
	localparam int LN     = tcma_pkg::LANES;

	tcma_pkg::state_t state_q;

	logic [SB-1:0]       sample_q [LN];
	logic [2*SB-1:0]     ring_mem [WINDOW];
	logic [2*SB-1:0]     rd_data_q;
	logic [SLOT_W-1:0]   slot_q;
	logic [CNT_W-1:0]    fill_q;
	logic [SUM_W-1:0]    sum_q [LN];
	logic [SUM_W-1:0]    sum_next [LN];
	logic [REM_W-1:0]    rem_q [LN];
	logic [Q_W-1:0]      quot_q [LN];
	logic [REM_W:0]      rem_sh [LN];
	logic                quot_bit [LN];
	logic [REM_W:0]      div_ext;
	logic [DCNT_W-1:0]   div_cnt_q;
	logic                full;
	logic                in_take;
	logic                out_load;
	logic                m_valid_q;
	logic [tcma_pkg::AVG_W-1:0]  avg_q [LN];
	logic [tcma_pkg::HELD_W-1:0] held_q;

	assign s_axis_tready = (state_q == tcma_pkg::ST_IDLE);
	assign in_take       = s_axis_tvalid && s_axis_tready;
	assign out_load      = (state_q == tcma_pkg::ST_DONE) && (!m_valid_q || m_axis_tready);
	assign full          = (fill_q == CNT_W'(WINDOW));
	assign div_ext       = (REM_W+1)'(fill_q);

	always_comb begin
		for (int i = 0; i < LN; i++) begin
			sum_next[i] = sum_q[i]
				- (full ? SUM_W'(rd_data_q[i*SB +: SB]) : SUM_W'(0))
				+ SUM_W'(sample_q[i]);
			rem_sh[i]   = {rem_q[i], quot_q[i][Q_W-1]};
			quot_bit[i] = (rem_sh[i] >= div_ext);
		end
	end

	// ring memory, both channels side by side in one word
	always_ff @(posedge clk) begin
		if (state_q == tcma_pkg::ST_LOAD) begin
			ring_mem[slot_q] <= {sample_q[1], sample_q[0]};
		end
		rd_data_q <= ring_mem[slot_q];
	end

	always_ff @(posedge clk) begin
		if (in_take) begin
			sample_q[0] <= s_axis_tdata[SB-1:0];
			sample_q[1] <= s_axis_tdata[2*SB-1:SB];
		end
	end

	// bit-serial restoring divider, one lane per channel
	always_ff @(posedge clk) begin
		if (state_q == tcma_pkg::ST_LOAD) begin
			for (int i = 0; i < LN; i++) begin
				rem_q[i]  <= sum_next[i][SUM_W-1:SB];
				quot_q[i] <= {sum_next[i][SB-1:0], tcma_pkg::FRAC_W'(0)};
			end
		end else if (state_q == tcma_pkg::ST_DIV) begin
			for (int i = 0; i < LN; i++) begin
				rem_q[i]  <= quot_bit[i] ? REM_W'(rem_sh[i] - div_ext) : REM_W'(rem_sh[i]);
				quot_q[i] <= {quot_q[i][Q_W-2:0], quot_bit[i]};
			end
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			for (int i = 0; i < LN; i++) begin
				avg_q[i] <= tcma_pkg::AVG_W'(quot_q[i]);
			end
			held_q <= tcma_pkg::HELD_W'(fill_q);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= tcma_pkg::ST_IDLE;
			slot_q    <= '0;
			fill_q    <= '0;
			sum_q[0]  <= '0;
			sum_q[1]  <= '0;
			div_cnt_q <= '0;
			m_valid_q <= 1'b0;
		end else begin
			if (out_load) begin
				m_valid_q <= 1'b1;
			end else if (m_axis_tready) begin
				m_valid_q <= 1'b0;
			end
			unique case (state_q)
				tcma_pkg::ST_IDLE: begin
					if (in_take) begin
						state_q <= tcma_pkg::ST_LOAD;
					end
				end
				tcma_pkg::ST_LOAD: begin
					sum_q[0]  <= sum_next[0];
					sum_q[1]  <= sum_next[1];
					slot_q    <= (slot_q == SLOT_W'(WINDOW - 1)) ? '0 : slot_q + 1'b1;
					if (!full) begin
						fill_q <= fill_q + 1'b1;
					end
					div_cnt_q <= DCNT_W'(Q_W - 1);
					state_q   <= tcma_pkg::ST_DIV;
				end
				tcma_pkg::ST_DIV: begin
					div_cnt_q <= div_cnt_q - 1'b1;
					if (div_cnt_q == '0) begin
						state_q <= tcma_pkg::ST_DONE;
					end
				end
				tcma_pkg::ST_DONE: begin
					if (out_load) begin
						state_q <= tcma_pkg::ST_IDLE;
					end
				end
				default: begin
					state_q <= tcma_pkg::ST_IDLE;
				end
			endcase
		end
	end

	assign m_axis_tvalid = m_valid_q;
	assign m_axis_tdata  = {tcma_pkg::OUT_PAD_W'(0), held_q, avg_q[1], avg_q[0]};

	a_take_starts_load: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && s_axis_tready |=> state_q == tcma_pkg::ST_LOAD)
		else $error("input word taken but sum update did not follow");

	a_fill_bounded: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= CNT_W'(WINDOW))
		else $error("fill count above window");

	a_rem_below_div: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == tcma_pkg::ST_DIV |-> ((REM_W+1)'(rem_q[0]) < div_ext)
			&& ((REM_W+1)'(rem_q[1]) < div_ext))
		else $error("divider remainder not below divisor");

	a_valid_from_done: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_axis_tvalid) |-> $past(state_q == tcma_pkg::ST_DONE))
		else $error("output word appeared without a finished division");

endmodule
